@@ rtl/dbo_pkg.sv @@
// Shared types and constants for the dyadic block occupancy counter.
package dbo_pkg;

    // Configuration port geometry.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // Reset value of both grid size registers.
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result count width and saturation value.
    localparam int              COUNT_W   = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    // Input field widths.
    localparam int CELL_W  = 6;
    localparam int LEVEL_W = 3;
    localparam int BLOCK_W = 7;

    // Width used for block coordinate arithmetic before clipping.
    localparam int GEOM_W = 16;

endpackage

@@ rtl/dyadic_block_occupancy_count.sv @@
// Top level: control sequencer, configuration registers and result register.
// A write word goes through a row read, a modify and write back (skipped when out of range) and FINISH.
// A query reads the R block rows inside the grid (at most GRID_DIM) in turn:
// the row memory delivers one row per cycle into a two-stage row count and an accumulator.
// One word is in work at a time; the next word is accepted while a result waits to be taken.
// Reset clears the grid through per-row valid bits, so the block is ready right after reset.
module dyadic_block_occupancy_count
    import dbo_pkg::*;
#(
    parameter int GRID_DIM = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Request channel.
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 req_type,
    input  logic [CELL_W-1:0]    cell_row,
    input  logic [CELL_W-1:0]    cell_col,
    input  logic                 cell_value,
    input  logic [LEVEL_W-1:0]   block_level,
    input  logic [BLOCK_W-1:0]   block_x,
    input  logic [BLOCK_W-1:0]   block_y,
    // Response channel.
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [COUNT_W-1:0]   occupied_count,
    output logic                 was_query
);

    localparam int AW    = $clog2(GRID_DIM);
    localparam int CW    = $clog2(GRID_DIM + 1);
    localparam int ACC_W = $clog2(GRID_DIM * GRID_DIM + 1);

    typedef enum logic [2:0] {
        IDLE,
        WR_READ,
        WR_MODIFY,
        Q_SETUP,
        Q_ISSUE,
        Q_DRAIN,
        FINISH
    } state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     grid_rows_reg;
    logic [CFG_W-1:0]     grid_cols_reg;

    logic                 query_reg;
    logic [CELL_W-1:0]    row_reg;
    logic [CELL_W-1:0]    col_reg;
    logic                 value_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [BLOCK_W-1:0]   bx_reg;
    logic [BLOCK_W-1:0]   by_reg;

    logic [CW-1:0]        row_ptr_reg;
    logic [CW-1:0]        row_end_reg;
    logic [GRID_DIM-1:0]  col_mask_reg;
    logic [ACC_W-1:0]     acc_reg;

    logic                 rsp_valid_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 was_query_reg;

    // Memory and row count connections.
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic                 mem_wr_en;
    logic [GRID_DIM-1:0]  mem_wr_data;
    logic [GRID_DIM-1:0]  mem_rd_data;
    logic                 mem_rd_valid;
    logic [CW-1:0]        row_sum;
    logic                 sum_valid;
    logic                 cnt_busy;

    // Decoded write address.
    logic [8:0]           row9;
    logic [8:0]           col9;
    logic                 wr_in_range;

    // Block geometry for the query setup.
    logic [8:0]           lim_rows9;
    logic [8:0]           lim_cols9;
    logic [BLOCK_W-1:0]   bx_m1;
    logic [BLOCK_W-1:0]   by_m1;
    logic [GEOM_W-1:0]    side16;
    logic [GEOM_W-1:0]    r_start;
    logic [GEOM_W-1:0]    c_start;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        c_lo;
    logic [CW-1:0]        c_hi;
    logic                 block_empty;
    logic [GRID_DIM-1:0]  col_mask_next;
    logic                 out_free;
    logic [COUNT_W-1:0]   final_count;

    // Clamp a coordinate to the active grid limit.
    function automatic logic [GEOM_W-1:0] clip_to(input logic [GEOM_W-1:0] v,
                                                 input logic [GEOM_W-1:0] lim);
        clip_to = (v < lim) ? v : lim;
    endfunction

    // Write address decode and read-modify-write data.
    always_comb
    begin
        row9        = 9'(row_reg);
        col9        = 9'(col_reg);
        wr_in_range = (row9 < 9'(GRID_DIM)) && (col9 < 9'(GRID_DIM));
        for (int j = 0; j < GRID_DIM; j++)
        begin
            mem_wr_data[j] = (9'(j) == col9) ? value_reg : mem_rd_data[j];
        end
    end

    // Block bounds, clipped to the configured grid.
    always_comb
    begin
        lim_rows9 = (9'(grid_rows_reg) > 9'(GRID_DIM)) ? 9'(GRID_DIM) : 9'(grid_rows_reg);
        lim_cols9 = (9'(grid_cols_reg) > 9'(GRID_DIM)) ? 9'(GRID_DIM) : 9'(grid_cols_reg);
        bx_m1     = bx_reg - BLOCK_W'(1);
        by_m1     = by_reg - BLOCK_W'(1);
        side16    = GEOM_W'(1) << level_reg;
        r_start   = GEOM_W'(bx_m1) << level_reg;
        c_start   = GEOM_W'(by_m1) << level_reg;
        r_lo      = CW'(clip_to(r_start, GEOM_W'(lim_rows9)));
        r_hi      = CW'(clip_to(r_start + side16, GEOM_W'(lim_rows9)));
        c_lo      = CW'(clip_to(c_start, GEOM_W'(lim_cols9)));
        c_hi      = CW'(clip_to(c_start + side16, GEOM_W'(lim_cols9)));
        // A zero block index lies wholly before the grid.
        block_empty = (bx_reg == '0) || (by_reg == '0) || (r_lo >= r_hi) || (c_lo >= c_hi);
        for (int j = 0; j < GRID_DIM; j++)
        begin
            col_mask_next[j] = (CW'(j) >= c_lo) && (CW'(j) < c_hi);
        end
    end

    // Memory access control.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = row_ptr_reg[AW-1:0];
        mem_wr_en   = 1'b0;
        unique case (state_reg)
            WR_READ:
            begin
                mem_rd_en   = wr_in_range;
                mem_rd_addr = row9[AW-1:0];
            end
            WR_MODIFY:
            begin
                mem_wr_en   = 1'b1;
            end
            Q_ISSUE:
            begin
                mem_rd_en   = 1'b1;
            end
            default:
            begin
                mem_rd_en   = 1'b0;
            end
        endcase
    end

    // Result value with saturation.
    always_comb
    begin
        if (32'(acc_reg) > 32'(COUNT_MAX))
        begin
            final_count = COUNT_MAX;
        end
        else
        begin
            final_count = COUNT_W'(acc_reg);
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Sequencer, item registers and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            grid_rows_reg <= GRID_SIZE_RESET;
            grid_cols_reg <= GRID_SIZE_RESET;
            rsp_valid_reg <= 1'b0;
            query_reg     <= 1'b0;
            row_ptr_reg   <= '0;
            row_end_reg   <= '0;
            acc_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            value_reg     <= 1'b0;
            level_reg     <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            col_mask_reg  <= '0;
            count_reg     <= '0;
            was_query_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                    REG_GRID_COLS: grid_cols_reg <= cfg_data;
                endcase
            end

            // Result leaves when taken.
            if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // Row sums arrive from the count pipeline.
            if (sum_valid)
            begin
                acc_reg <= acc_reg + ACC_W'(row_sum);
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (req_valid)
                    begin
                        query_reg <= req_type;
                        row_reg   <= cell_row;
                        col_reg   <= cell_col;
                        value_reg <= cell_value;
                        level_reg <= block_level;
                        bx_reg    <= block_x;
                        by_reg    <= block_y;
                        state_reg <= (req_type == REQ_QUERY) ? Q_SETUP : WR_READ;
                    end
                end
                WR_READ:
                begin
                    state_reg <= wr_in_range ? WR_MODIFY : FINISH;
                end
                WR_MODIFY:
                begin
                    state_reg <= FINISH;
                end
                Q_SETUP:
                begin
                    acc_reg      <= '0;
                    row_ptr_reg  <= r_lo;
                    row_end_reg  <= r_hi;
                    col_mask_reg <= col_mask_next;
                    state_reg    <= block_empty ? FINISH : Q_ISSUE;
                end
                Q_ISSUE:
                begin
                    row_ptr_reg <= row_ptr_reg + CW'(1);
                    if (row_ptr_reg + CW'(1) == row_end_reg)
                    begin
                        state_reg <= Q_DRAIN;
                    end
                end
                Q_DRAIN:
                begin
                    if (!mem_rd_valid && !cnt_busy)
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        was_query_reg <= query_reg;
                        count_reg     <= (query_reg == REQ_QUERY) ? final_count : '0;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign req_stall      = (state_reg != IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign occupied_count = count_reg;
    assign was_query      = was_query_reg;

    dbo_row_mem #(
        .GRID_DIM (GRID_DIM)
    ) u_row_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .wr_en    (mem_wr_en),
        .wr_addr  (row9[AW-1:0]),
        .wr_data  (mem_wr_data),
        .rd_data  (mem_rd_data),
        .rd_valid (mem_rd_valid)
    );

    // Only query reads feed the counter; write reads are consumed by the modify step.
    dbo_row_count #(
        .GRID_DIM (GRID_DIM)
    ) u_row_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (mem_rd_valid && (query_reg == REQ_QUERY)),
        .row_data  (mem_rd_data),
        .col_mask  (col_mask_reg),
        .row_sum   (row_sum),
        .sum_valid (sum_valid),
        .busy      (cnt_busy)
    );

endmodule

@@ rtl/dbo_row_mem.sv @@
// Occupancy row memory: one grid row per word, registered read, per-row valid bits.
module dbo_row_mem
    import dbo_pkg::*;
#(
    parameter int GRID_DIM = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(GRID_DIM)-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(GRID_DIM)-1:0] wr_addr,
    input  logic [GRID_DIM-1:0]         wr_data,
    output logic [GRID_DIM-1:0]         rd_data,
    output logic                        rd_valid
);

    logic [GRID_DIM-1:0] mem_reg [GRID_DIM];
    logic [GRID_DIM-1:0] data_reg;
    logic [GRID_DIM-1:0] row_valid_reg;
    logic                live_reg;
    logic                rd_valid_reg;

    // Storage array and read data register; no reset on the payload.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
        end
    end

    // Row valid bits stand in for clearing the array at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            live_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (rd_en)
            begin
                live_reg <= row_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // A row never written reads as all clear.
    assign rd_data  = live_reg ? data_reg : '0;
    assign rd_valid = rd_valid_reg;

endmodule

@@ rtl/dbo_row_count.sv @@
// Two-stage population count of one masked grid row.
module dbo_row_count
    import dbo_pkg::*;
#(
    parameter int GRID_DIM = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          row_valid,
    input  logic [GRID_DIM-1:0]           row_data,
    input  logic [GRID_DIM-1:0]           col_mask,
    output logic [$clog2(GRID_DIM+1)-1:0] row_sum,
    output logic                          sum_valid,
    output logic                          busy
);

    localparam int NB    = (GRID_DIM + 7) / 8;
    localparam int PAD_W = NB * 8;
    localparam int SUM_W = $clog2(GRID_DIM + 1);

    logic [PAD_W-1:0]     padded;
    logic [NB-1:0][3:0]   byte_cnt_next;
    logic [NB-1:0][3:0]   byte_cnt_reg;
    logic                 a_valid_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [SUM_W-1:0]     sum_reg;
    logic                 sum_valid_reg;

    // First stage: count each byte of the masked row.
    always_comb
    begin
        padded = PAD_W'(row_data & col_mask);
        for (int b = 0; b < NB; b++)
        begin
            byte_cnt_next[b] = 4'd0;
            for (int k = 0; k < 8; k++)
            begin
                byte_cnt_next[b] = byte_cnt_next[b] + 4'(padded[b*8+k]);
            end
        end
    end

    // Second stage: add the byte counts.
    always_comb
    begin
        sum_next = '0;
        for (int b = 0; b < NB; b++)
        begin
            sum_next = sum_next + SUM_W'(byte_cnt_reg[b]);
        end
    end

    always_ff @(posedge clk)
    begin
        byte_cnt_reg <= byte_cnt_next;
        sum_reg      <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= row_valid;
            sum_valid_reg <= a_valid_reg;
        end
    end

    assign row_sum   = sum_reg;
    assign sum_valid = sum_valid_reg;
    assign busy      = a_valid_reg | sum_valid_reg;

endmodule

@@ rtl/dbo_check.sv @@
// Port-level checker for the occupancy counter and its bind to the top level.
module dbo_check
    import dbo_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [COUNT_W-1:0] occupied_count,
    input logic               was_query
);

    // A stalled result word holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(occupied_count) && $stable(was_query))
        else $error("stalled result word changed");

    // A write acknowledge always carries a zero count.
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !was_query |-> occupied_count == '0)
        else $error("write acknowledge with nonzero count");

    // Once a word is taken in, the request side stalls while it is worked on.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while busy");

    // No result appears in the cycle right after a request is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !$rose(rsp_valid))
        else $error("result appeared too early");

endmodule

bind dyadic_block_occupancy_count dbo_check u_dbo_check (.*);

@@ dv/tb_dyadic_block_occupancy_count.sv @@
// Self-checking testbench for the dyadic block occupancy counter.
module tb_dyadic_block_occupancy_count;
    import dbo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID = 64;
    // Longest query walks every grid row and then drains the pipeline.
    localparam int DRAIN_PAD = GRID + 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic                 kind;
        logic [CELL_W-1:0]    row;
        logic [CELL_W-1:0]    col;
        logic                 value;
        logic [LEVEL_W-1:0]   level;
        logic [BLOCK_W-1:0]   bx;
        logic [BLOCK_W-1:0]   by;
        bit                   drain_first;
    } grid_word_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               query;
    } grid_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_ROWS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic                 req_type = REQ_WRITE;
    logic [CELL_W-1:0]    cell_row = '0;
    logic [CELL_W-1:0]    cell_col = '0;
    logic                 cell_value = 1'b0;
    logic [LEVEL_W-1:0]   block_level = '0;
    logic [BLOCK_W-1:0]   block_x = '0;
    logic [BLOCK_W-1:0]   block_y = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [COUNT_W-1:0]   occupied_count;
    logic                 was_query;

    // Local copy of the grid and of the size registers.
    logic [GRID-1:0]      grid_model [GRID] = '{default: '0};
    logic [CFG_W-1:0]     rows_in_use = GRID_SIZE_RESET;
    logic [CFG_W-1:0]     cols_in_use = GRID_SIZE_RESET;

    grid_word_t           pending_words [$];
    grid_result_t         expected_results [$];
    grid_word_t           on_bus;

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_go = 1'b0;
    int hold_left = 0;

    int words_queued = 0;
    int words_accepted = 0;
    int mismatches = 0;
    int writes_seen = 0;
    int queries_seen = 0;
    int nonzero_counts = 0;
    int peak_count = 0;
    int settings_used = 0;

    dyadic_block_occupancy_count #(.GRID_DIM(GRID)) dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int clamp_to(input int v, input int lim);
        if (v < 0)
            return 0;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Occupied cells of the dyadic block, clipped to the rows and columns in use.
    function automatic logic [COUNT_W-1:0] count_occupied(input logic [LEVEL_W-1:0] lvl,
                                                          input logic [BLOCK_W-1:0] bx,
                                                          input logic [BLOCK_W-1:0] by);
        int side, row_lim, col_lim, r0, c0, r_lo, r_hi, c_lo, c_hi, total;
        side = 1 << lvl;
        row_lim = (rows_in_use < GRID) ? int'(rows_in_use) : GRID;
        col_lim = (cols_in_use < GRID) ? int'(cols_in_use) : GRID;
        r0 = (int'(bx) - 1) * side;
        c0 = (int'(by) - 1) * side;
        r_lo = clamp_to(r0, row_lim);
        r_hi = clamp_to(r0 + side, row_lim);
        c_lo = clamp_to(c0, col_lim);
        c_hi = clamp_to(c0 + side, col_lim);
        total = 0;
        for (int r = r_lo; r < r_hi; r++)
            for (int c = c_lo; c < c_hi; c++)
                total += grid_model[r][c];
        if (total > int'(COUNT_MAX))
            total = COUNT_MAX;
        return total[COUNT_W-1:0];
    endfunction

    // Apply an accepted word to the grid copy and record what it must return.
    task automatic predict_word(input grid_word_t w);
        grid_result_t res;
        if (w.kind == REQ_WRITE)
        begin
            if (w.row < GRID && w.col < GRID)
                grid_model[w.row][w.col] = w.value;
            res.count = '0;
            res.query = 1'b0;
            writes_seen++;
        end
        else
        begin
            res.count = count_occupied(w.level, w.bx, w.by);
            res.query = 1'b1;
            queries_seen++;
            if (res.count != 0)
                nonzero_counts++;
            if (int'(res.count) > peak_count)
                peak_count = res.count;
        end
        expected_results.push_back(res);
    endtask

    // Unused fields carry random bits so that every input bit toggles.
    function automatic grid_word_t random_fill();
        grid_word_t w;
        w.kind = REQ_WRITE;
        w.row = CELL_W'($urandom_range(GRID - 1));
        w.col = CELL_W'($urandom_range(GRID - 1));
        w.value = 1'($urandom_range(1));
        w.level = LEVEL_W'($urandom_range(7));
        w.bx = BLOCK_W'($urandom_range(127));
        w.by = BLOCK_W'($urandom_range(127));
        w.drain_first = 1'b0;
        return w;
    endfunction

    function automatic grid_word_t make_write(input int r, input int c, input int v);
        grid_word_t w;
        w = random_fill();
        w.kind = REQ_WRITE;
        w.row = CELL_W'(r);
        w.col = CELL_W'(c);
        w.value = 1'(v);
        return w;
    endfunction

    function automatic grid_word_t make_query(input int s, input int x, input int y);
        grid_word_t w;
        w = random_fill();
        w.kind = REQ_QUERY;
        w.level = LEVEL_W'(s);
        w.bx = BLOCK_W'(x);
        w.by = BLOCK_W'(y);
        return w;
    endfunction

    // Queries mostly name blocks on or just around the grid; a few are wild.
    function automatic grid_word_t random_word(input int write_pct, input int set_pct);
        grid_word_t w;
        int lvl, span;
        if ($urandom_range(99) < write_pct)
            return make_write($urandom_range(GRID - 1), $urandom_range(GRID - 1),
                              $urandom_range(99) < set_pct);
        lvl = ($urandom_range(19) == 0) ? 7 : $urandom_range(6);
        span = (lvl == 7) ? 1 : (GRID >> lvl);
        if ($urandom_range(9) == 0)
            w = make_query(lvl, $urandom_range(127), $urandom_range(127));
        else
            w = make_query(lvl, $urandom_range(span + 1), $urandom_range(span + 1));
        return w;
    endfunction

    task automatic queue_word(input grid_word_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Wait until every queued word is taken and answered, then let the block settle.
    task automatic settle();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Both size registers, written back to back while the block is idle.
    task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_data <= rows;
        @(posedge clk);
        cfg_index <= REG_GRID_COLS;
        cfg_data <= cols;
        @(posedge clk);
        cfg_we <= 1'b0;
        rows_in_use = rows;
        cols_in_use = cols;
        settings_used++;
    endtask

    task automatic run_phase(input int n, input int write_pct, input int set_pct,
                             input int send_pct, input int stall, input int drain_every,
                             input bit long_hold);
        grid_word_t w;
        int base;
        send_idle_pct = send_pct;
        stall_pct = stall;
        base = words_accepted;
        for (int i = 0; i < n; i++)
        begin
            w = random_word(write_pct, set_pct);
            w.drain_first = (drain_every != 0) && (i % drain_every == drain_every / 2);
            queue_word(w);
        end
        if (long_hold)
        begin
            while (words_accepted < base + 20)
                @(posedge clk);
            @(posedge clk);
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        settle();
    endtask

    // Long receiver hold-off, counted down here.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Driver: a word stays on the bus until taken, then the next one may follow.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_word(on_bus);
                words_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    (!pending_words[0].drain_first || expected_results.size() == 0))
                begin
                    on_bus = pending_words.pop_front();
                    req_valid <= 1'b1;
                    req_type <= on_bus.kind;
                    cell_row <= on_bus.row;
                    cell_col <= on_bus.col;
                    cell_value <= on_bus.value;
                    block_level <= on_bus.level;
                    block_x <= on_bus.bx;
                    block_y <= on_bus.by;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        if (mismatches < 10)
            $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    // Monitor: random stalls, and each taken result checked against the oldest prediction.
    always @(posedge clk)
    begin
        grid_result_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    note_mismatch("unexpected result word, count", -1, occupied_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (occupied_count !== want.count)
                        note_mismatch("occupied_count", want.count, occupied_count);
                    if (was_query !== want.query)
                        note_mismatch("was_query", want.query, was_query);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words on the reset grid size: corners, a clear, and odd blocks.
        queue_word(make_write(0, 0, 1));
        queue_word(make_write(63, 63, 1));
        queue_word(make_write(0, 63, 1));
        queue_word(make_write(63, 0, 1));
        queue_word(make_write(31, 32, 1));
        queue_word(make_write(5, 5, 1));
        queue_word(make_write(5, 5, 0));
        queue_word(make_query(6, 1, 1));
        queue_word(make_query(0, 1, 1));
        queue_word(make_query(0, 64, 64));
        queue_word(make_query(7, 1, 1));
        queue_word(make_query(0, 0, 1));
        queue_word(make_query(0, 1, 0));
        queue_word(make_query(5, 2, 2));
        queue_word(make_query(3, 127, 127));
        queue_word(make_query(1, 32, 32));
        queue_word(make_query(0, 6, 6));
        queue_word(make_query(2, 64, 1));
        queue_word(make_query(5, 1, 2));
        queue_word(make_query(4, 2, 3));
        queue_word(make_write(63, 63, 0));
        queue_word(make_query(6, 1, 1));
        settle();

        // Random phases over several grid sizes and idling patterns.
        set_grid(7'd64, 7'd64);
        run_phase(200, 60, 70, 0, 0, 0, 1'b0);
        run_phase(200, 50, 60, 0, 46, 25, 1'b1);
        set_grid(7'd1, 7'd64);
        run_phase(150, 50, 60, 46, 0, 0, 1'b0);
        set_grid(7'd0, 7'd17);
        run_phase(100, 50, 60, 21, 21, 0, 1'b0);
        set_grid(7'd127, 7'd127);
        run_phase(200, 40, 50, 46, 0, 0, 1'b0);
        set_grid(7'd37, 7'd50);
        run_phase(150, 50, 50, 0, 46, 30, 1'b0);
        set_grid(7'd23, 7'd100);
        run_phase(150, 50, 40, 21, 21, 0, 1'b0);
        set_grid(7'd64, 7'd1);
        run_phase(120, 60, 20, 0, 0, 0, 1'b0);
        set_grid(CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)));
        run_phase(130, 50, 50, 21, 21, 0, 1'b0);
        set_grid(7'd64, 7'd64);
        run_phase(130, 40, 50, 46, 0, 0, 1'b0);

        repeat (DRAIN_PAD) @(posedge clk);
        if (expected_results.size() != 0)
            note_mismatch("results still outstanding", 0, expected_results.size());

        $display("Ran %0d grid writes and %0d block queries under %0d grid size settings.",
                 writes_seen, queries_seen, settings_used);
        $display("%0d queries found occupied cells, the largest count being %0d; %0d mismatches.",
                 nonzero_counts, peak_count, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("Run timed out with %0d results outstanding.", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dbo_pkg.sv
rtl/dbo_row_mem.sv
rtl/dbo_row_count.sv
rtl/dyadic_block_occupancy_count.sv
rtl/dbo_check.sv
dv/tb_dyadic_block_occupancy_count.sv
